// ----- hw/rtl/c_integer_literal_parser_assert.svh -----
// Assertion macros for the integer literal parser.
`ifndef C_INTEGER_LITERAL_PARSER_ASSERT_SVH
`define C_INTEGER_LITERAL_PARSER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked while out of reset.
`define CILP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cilp assertion failed");
// Next-cycle implication, checked while out of reset.
`define CILP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cilp assertion failed");
`else
`define CILP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CILP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/cilp_pkg.sv -----
// Package with types, constants and helpers of the integer literal parser.
`default_nettype none
package cilp_pkg;

    localparam int CILP_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2,
        BASE_BIN = 2'd3
    } cilp_base_t;

    typedef enum logic [3:0] {
        PH_DIGITS = 4'd0,
        PH_PREFIX = 4'd1,
        PH_L      = 4'd2,
        PH_LOW_L  = 4'd3,
        PH_LL     = 4'd4,
        PH_U      = 4'd5,
        PH_UL     = 4'd6,
        PH_ULOW   = 4'd7,
        PH_DONE   = 4'd8
    } cilp_phase_t;

    typedef enum logic [1:0] {
        TYPE_INT   = 2'd0,
        TYPE_UINT  = 2'd1,
        TYPE_LONG  = 2'd2,
        TYPE_ULONG = 2'd3
    } cilp_type_t;

    // Classified character, as queued between front and back.
    typedef struct packed {
        logic [3:0] dval;      // digit value for hex digits
        logic [3:0] dig_ok;    // digit valid in base, indexed by cilp_base_t
        logic       is_zero;
        logic       is_nzdec;  // 1..9
        logic       is_x;      // x or X
        logic       is_b;      // b or B
        logic       is_upl;    // L
        logic       is_lowl;   // l
        logic       is_u;      // u or U
        logic       last;
    } cilp_class_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cilp_fifo_stat_t;

    typedef struct packed {
        logic take;
        logic load;
    } cilp_back_stat_t;

    function automatic cilp_type_t cilp_pick_type(
        input logic [63:0] v,
        input logic        dec,
        input logic        l,
        input logic        u
    );
        cilp_type_t t;
        if (l && u) begin
            t = TYPE_ULONG;
        end else if (dec) begin
            if (l)      t = TYPE_LONG;
            else if (u) t = (|v[63:32]) ? TYPE_ULONG : TYPE_UINT;
            else        t = (|v[63:31]) ? TYPE_LONG : TYPE_INT;
        end else begin
            if (l)              t = v[63] ? TYPE_ULONG : TYPE_LONG;
            else if (u)         t = (|v[63:32]) ? TYPE_ULONG : TYPE_UINT;
            else if (v[63])     t = TYPE_ULONG;
            else if (|v[62:32]) t = TYPE_LONG;
            else if (v[31])     t = TYPE_UINT;
            else                t = TYPE_INT;
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cilp_front.sv -----
// Front end: classify each incoming character for the back end.
`default_nettype none
module cilp_front
    import cilp_pkg::*;
(
    input  wire logic [7:0] char_in,
    input  wire logic       last_in,
    output cilp_class_t     cls
);
    logic is_dec;
    logic is_lowhex;
    logic is_uphex;

    always_comb begin
        is_dec    = char_in inside {["0":"9"]};
        is_lowhex = char_in inside {["a":"f"]};
        is_uphex  = char_in inside {["A":"F"]};

        cls.dval       = is_dec ? char_in[3:0] : (char_in[3:0] + 4'd9);
        cls.dig_ok[BASE_DEC] = is_dec;
        cls.dig_ok[BASE_OCT] = char_in inside {["0":"7"]};
        cls.dig_ok[BASE_HEX] = is_dec || is_lowhex || is_uphex;
        cls.dig_ok[BASE_BIN] = char_in inside {"0", "1"};
        cls.is_zero    = (char_in == "0");
        cls.is_nzdec   = char_in inside {["1":"9"]};
        cls.is_x       = char_in inside {"x", "X"};
        cls.is_b       = char_in inside {"b", "B"};
        cls.is_upl     = (char_in == "L");
        cls.is_lowl    = (char_in == "l");
        cls.is_u       = char_in inside {"u", "U"};
        cls.last       = last_in;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/cilp_fifo.sv -----
// Short queue of classified characters between front and back end.
`default_nettype none
module cilp_fifo
    import cilp_pkg::*;
#(
    parameter int DEPTH = CILP_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  cilp_class_t      wr_data,
    input  wire logic        pop,
    output cilp_class_t      rd_data,
    output cilp_fifo_stat_t  stat
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cilp_class_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
endmodule
`default_nettype wire

// ----- hw/rtl/cilp_back.sv -----
// Back end: base selection, digit accumulation, suffix parsing and result register.
`default_nettype none
module cilp_back
    import cilp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  cilp_class_t       in_cls,
    output cilp_back_stat_t   stat,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              out_ok,
    output logic [63:0]       out_value,
    output logic [1:0]        out_type
);
    logic [1:0]   cnt_reg,   cnt_next;
    cilp_base_t   base_reg,  base_next;
    logic [63:0]  acc_reg,   acc_next;
    logic         ovf_reg,   ovf_next;
    cilp_phase_t  phase_reg, phase_next;
    logic         mark_l_reg, mark_l_next;
    logic         mark_u_reg, mark_u_next;
    logic         rej_reg,   rej_next;
    logic         pfx_x_reg, pfx_x_next;

    logic         vld_reg,   vld_next;
    logic         ok_reg;
    logic [63:0]  val_reg;
    logic         dec_reg, l_reg, u_reg;

    logic         take;
    logic         load;
    logic         ok_now;
    logic [67:0]  scaled;
    logic [67:0]  summed;

    assign take = in_valid && (!in_cls.last || !vld_reg || out_ready);
    assign load = take && in_cls.last;
    assign stat.take = take;
    assign stat.load = load;

    // Multiply by the radix as shifts and adds.
    always_comb begin
        case (base_reg)
            BASE_DEC: scaled = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
            BASE_OCT: scaled = {1'b0, acc_reg, 3'b000};
            BASE_HEX: scaled = {acc_reg, 4'b0000};
            BASE_BIN: scaled = {3'b000, acc_reg, 1'b0};
            default:  scaled = '0;
        endcase
        summed = scaled + {64'd0, in_cls.dval};
    end

    always_comb begin
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        phase_next  = phase_reg;
        mark_l_next = mark_l_reg;
        mark_u_next = mark_u_reg;
        rej_next    = rej_reg;
        pfx_x_next  = pfx_x_reg;
        ok_now      = 1'b0;

        if (take) begin
            if (!rej_reg) begin
                if (cnt_reg == 2'd0) begin
                    if (in_cls.is_zero) begin
                        base_next = BASE_OCT;
                        acc_next  = '0;
                    end else if (in_cls.is_nzdec) begin
                        base_next = BASE_DEC;
                        acc_next  = {60'd0, in_cls.dval};
                    end else begin
                        rej_next = 1'b1;
                    end
                end else if (phase_reg == PH_PREFIX) begin
                    phase_next = PH_DIGITS;
                    if (pfx_x_reg && in_cls.dig_ok[BASE_HEX]) begin
                        base_next = BASE_HEX;
                        acc_next  = {60'd0, in_cls.dval};
                    end else if (!pfx_x_reg && in_cls.dig_ok[BASE_BIN]) begin
                        base_next = BASE_BIN;
                        acc_next  = {60'd0, in_cls.dval};
                    end else begin
                        rej_next = 1'b1;
                    end
                end else if (cnt_reg == 2'd1 && base_reg == BASE_OCT &&
                             (in_cls.is_x || in_cls.is_b)) begin
                    pfx_x_next = in_cls.is_x;
                    phase_next = PH_PREFIX;
                end else if (phase_reg == PH_DIGITS && in_cls.dig_ok[base_reg]) begin
                    if (!ovf_reg) begin
                        if (|summed[67:64]) begin
                            acc_next = '1;
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = summed[63:0];
                        end
                    end
                end else begin
                    case (phase_reg)
                        PH_DIGITS: begin
                            if (in_cls.is_upl) begin
                                phase_next  = PH_L;
                                mark_l_next = 1'b1;
                            end else if (in_cls.is_lowl) begin
                                phase_next  = PH_LOW_L;
                                mark_l_next = 1'b1;
                            end else if (in_cls.is_u) begin
                                phase_next  = PH_U;
                                mark_u_next = 1'b1;
                            end else begin
                                rej_next = 1'b1;
                            end
                        end
                        PH_L, PH_LOW_L: begin
                            if ((phase_reg == PH_L && in_cls.is_upl) ||
                                (phase_reg == PH_LOW_L && in_cls.is_lowl)) begin
                                phase_next = PH_LL;
                            end else if (in_cls.is_u) begin
                                phase_next  = PH_DONE;
                                mark_u_next = 1'b1;
                            end else begin
                                rej_next = 1'b1;
                            end
                        end
                        PH_LL: begin
                            if (in_cls.is_u) begin
                                phase_next  = PH_DONE;
                                mark_u_next = 1'b1;
                            end else begin
                                rej_next = 1'b1;
                            end
                        end
                        PH_U: begin
                            if (in_cls.is_upl) begin
                                phase_next  = PH_UL;
                                mark_l_next = 1'b1;
                            end else if (in_cls.is_lowl) begin
                                phase_next  = PH_ULOW;
                                mark_l_next = 1'b1;
                            end else begin
                                rej_next = 1'b1;
                            end
                        end
                        PH_UL: begin
                            if (in_cls.is_upl) phase_next = PH_DONE;
                            else               rej_next   = 1'b1;
                        end
                        PH_ULOW: begin
                            if (in_cls.is_lowl) phase_next = PH_DONE;
                            else                rej_next   = 1'b1;
                        end
                        default: begin
                            rej_next = 1'b1;
                        end
                    endcase
                end
            end

            if (cnt_reg != 2'd3) begin
                cnt_next = cnt_reg + 2'd1;
            end

            if (in_cls.last) begin
                ok_now      = !rej_next && (phase_next != PH_PREFIX);
                cnt_next    = '0;
                base_next   = BASE_DEC;
                acc_next    = '0;
                ovf_next    = 1'b0;
                phase_next  = PH_DIGITS;
                mark_l_next = 1'b0;
                mark_u_next = 1'b0;
                rej_next    = 1'b0;
                pfx_x_next  = 1'b0;
            end
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            base_reg   <= BASE_DEC;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            phase_reg  <= PH_DIGITS;
            mark_l_reg <= 1'b0;
            mark_u_reg <= 1'b0;
            rej_reg    <= 1'b0;
            pfx_x_reg  <= 1'b0;
            vld_reg    <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            base_reg   <= base_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
            phase_reg  <= phase_next;
            mark_l_reg <= mark_l_next;
            mark_u_reg <= mark_u_next;
            rej_reg    <= rej_next;
            pfx_x_reg  <= pfx_x_next;
            vld_reg    <= vld_next;
        end
    end

    // Values of the state as updated by the last character, before the clear.
    function automatic logic [63:0] acc_next_pre_clear();
        logic [63:0] v;
        v = acc_reg;
        if (!rej_reg) begin
            if (cnt_reg == 2'd0) begin
                v = in_cls.is_zero ? 64'd0 : {60'd0, in_cls.dval};
            end else if (phase_reg == PH_PREFIX) begin
                v = {60'd0, in_cls.dval};
            end else if (!(cnt_reg == 2'd1 && base_reg == BASE_OCT &&
                           (in_cls.is_x || in_cls.is_b)) &&
                         phase_reg == PH_DIGITS && in_cls.dig_ok[base_reg] && !ovf_reg) begin
                v = (|summed[67:64]) ? '1 : summed[63:0];
            end
        end
        return v;
    endfunction

    function automatic cilp_base_t base_next_pre_clear();
        cilp_base_t b;
        b = base_reg;
        if (!rej_reg) begin
            if (cnt_reg == 2'd0) begin
                b = in_cls.is_zero ? BASE_OCT : BASE_DEC;
            end else if (phase_reg == PH_PREFIX) begin
                b = pfx_x_reg ? BASE_HEX : BASE_BIN;
            end
        end
        return b;
    endfunction

    function automatic logic mark_l_pre_clear();
        logic m;
        m = mark_l_reg;
        if (!rej_reg && cnt_reg != 2'd0 && phase_reg != PH_PREFIX &&
            !(phase_reg == PH_DIGITS && in_cls.dig_ok[base_reg])) begin
            if ((phase_reg == PH_DIGITS || phase_reg == PH_U) &&
                (in_cls.is_upl || in_cls.is_lowl)) begin
                m = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic mark_u_pre_clear();
        logic m;
        m = mark_u_reg;
        if (!rej_reg && cnt_reg != 2'd0 && phase_reg != PH_PREFIX &&
            !(phase_reg == PH_DIGITS && in_cls.dig_ok[base_reg])) begin
            if ((phase_reg == PH_DIGITS || phase_reg == PH_L || phase_reg == PH_LOW_L ||
                 phase_reg == PH_LL) && in_cls.is_u) begin
                m = 1'b1;
            end
        end
        return m;
    endfunction

    // Result payload; a rejected token is captured as all zeros.
    always_ff @(posedge aclk) begin
        if (load) begin
            ok_reg  <= ok_now;
            val_reg <= ok_now ? acc_next_pre_clear() : '0;
            dec_reg <= (base_next_pre_clear() == BASE_DEC);
            l_reg   <= ok_now && mark_l_pre_clear();
            u_reg   <= ok_now && mark_u_pre_clear();
        end
    end

    assign out_valid = vld_reg;
    assign out_ok    = ok_reg;
    assign out_value = val_reg;
    assign out_type  = ok_reg ? 2'(cilp_pick_type(val_reg, dec_reg, l_reg, u_reg)) : 2'(TYPE_INT);
endmodule
`default_nettype wire

// ----- hw/rtl/c_integer_literal_parser.sv -----
// Top level of the C integer constant lexer: front end, queue, back end.
// Throughput: one character per cycle unless results stall, with no bubbles between tokens.
// A result passes through the queue entry and is then loaded into the result register
// when the back end takes the last character, together with that character's digit step.
// The critical path is the back end's radix multiply, a 68-bit shift-and-add with carry out.
// Reset (aresetn low, synchronous): the queue empties, the token state clears, no result.
`default_nettype none
`include "c_integer_literal_parser_assert.svh"
module c_integer_literal_parser
    import cilp_pkg::*;
#(
    parameter int FIFO_DEPTH = CILP_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Character stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [63:0] literal_value, [65:64] type_code, rest zero
    output logic [0:0]       m_tuser    // [0] is_integer
);
    cilp_class_t      front_cls;
    cilp_class_t      queue_cls;
    cilp_fifo_stat_t  fifo_stat;
    cilp_back_stat_t  back_stat;
    logic             s_xfer;
    logic             res_ok;
    logic [63:0]      res_value;
    logic [1:0]       res_type;

    // Accept a character whenever the queue has room; the back end drains
    // it once per cycle, so the queue only fills while results are stalled.
    assign s_tready = !fifo_stat.full;
    assign s_xfer   = s_tvalid && s_tready;

    // Classify the character: digit value, per-base validity, prefix and suffix letters.
    cilp_front u_front (
        .char_in (s_tdata),
        .last_in (s_tlast),
        .cls     (front_cls)
    );

    // Decouple classification from accumulation so either side can stall.
    cilp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_xfer),
        .wr_data (front_cls),
        .pop     (back_stat.take),
        .rd_data (queue_cls),
        .stat    (fifo_stat)
    );

    // Advance the token state; on the last character load the result register
    // and clear the state for the next token.
    cilp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (!fifo_stat.empty),
        .in_cls    (queue_cls),
        .stat      (back_stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ok    (res_ok),
        .out_value (res_value),
        .out_type  (res_type)
    );

    // Pack the result transaction.
    assign m_tdata = {6'd0, res_type, res_value};
    assign m_tuser = res_ok;

    // A rejected token carries zero value and type.
    `CILP_ASSERT_IMPL(a_reject_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 72'd0)
    // A result is only loaded when the output register is free or draining.
    `CILP_ASSERT_IMPL(a_load_free, aclk, aresetn, back_stat.load, !m_tvalid || m_tready)
    // Never push into a full queue.
    `CILP_ASSERT_IMPL(a_no_overrun, aclk, aresetn, s_xfer, !fifo_stat.full)
    // A loaded result is presented in the next cycle.
    `CILP_ASSERT_NEXT(a_load_shows, aclk, aresetn, back_stat.load, m_tvalid)
endmodule
`default_nettype wire

// ----- test/tb_c_integer_literal_parser.sv -----
// Self-checking testbench for the C integer literal parser: directed tokens, then random tokens.
module tb_c_integer_literal_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import cilp_pkg::*;

    // Clock, reset and run length
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_CHARS = 640;
    localparam int DRAIN_CYCLES = 16;      // extra run time after the last result is checked
    localparam int CYCLE_LIMIT  = 200000;  // watchdog bound on the whole run

    // Pacing: percent of cycles a side idles, the stall-free window, the receiver hold-off
    localparam int IDLE_PCT     = 38;
    localparam int STEADY_FROM  = 400;
    localparam int STEADY_SPAN  = 200;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 80;

    // Suffix bookkeeping: bit 0 marks long, bit 1 marks unsigned
    localparam logic [1:0] MARK_LONG     = 2'b01;
    localparam logic [1:0] MARK_UNSIGNED = 2'b10;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // One answer of the lexer, as carried by m_tuser and m_tdata
    typedef struct packed {
        logic        is_int;
        logic [63:0] value;
        cilp_type_t  kind;
    } lex_result_t;

    localparam lex_result_t NOT_INT = '{1'b0, 64'd0, TYPE_INT};

    // One character transaction; fixed marks an answer typed into the token list
    typedef struct {
        logic [7:0]  code;
        logic        last;
        logic        fixed;
        lex_result_t want;
    } char_item_t;

    typedef struct {
        string       text;
        logic        fixed;
        lex_result_t want;
    } token_row_t;

    // Directed tokens. In the text, '#' stands for byte 0x00 and '$' for byte 0xFF.
    // Rows with fixed = 0 take their answer from the predictor.
    localparam int ROW_COUNT = 31;
    token_row_t token_rows [ROW_COUNT] = '{
        '{"0",                     1'b1, '{1'b1, 64'd0, TYPE_INT}},
        '{"#",                     1'b1, NOT_INT},
        '{"1$",                    1'b1, NOT_INT},
        '{"18446744073709551615",  1'b1, '{1'b1, ALL_ONES, TYPE_LONG}},
        '{"18446744073709551616",  1'b1, '{1'b1, ALL_ONES, TYPE_LONG}},
        '{"0xFFFFFFFFFFFFFFFF",    1'b1, '{1'b1, ALL_ONES, TYPE_ULONG}},
        '{"0X1ffffffffffffffffUL", 1'b1, '{1'b1, ALL_ONES, TYPE_ULONG}},
        '{"2147483647",            1'b0, NOT_INT},
        '{"2147483648",            1'b0, NOT_INT},
        '{"0x80000000",            1'b0, NOT_INT},
        '{"0b101",                 1'b0, NOT_INT},
        '{"0B1lu",                 1'b0, NOT_INT},
        '{"017L",                  1'b0, NOT_INT},
        '{"4294967296u",           1'b0, NOT_INT},
        '{"7LLU",                  1'b0, NOT_INT},
        '{"7uLL",                  1'b0, NOT_INT},
        '{"7Ul",                   1'b0, NOT_INT},
        '{"5ll",                   1'b0, NOT_INT},
        '{"0x7fffffffffffffffl",   1'b0, NOT_INT},
        '{"09",                    1'b1, NOT_INT},
        '{"x1",                    1'b1, NOT_INT},
        '{" 1",                    1'b1, NOT_INT},
        '{"-1",                    1'b1, NOT_INT},
        '{"0x",                    1'b1, NOT_INT},
        '{"0xg",                   1'b1, NOT_INT},
        '{"0b2",                   1'b1, NOT_INT},
        '{"0x0x1",                 1'b1, NOT_INT},
        '{"1uLl",                  1'b1, NOT_INT},
        '{"1Ll",                   1'b1, NOT_INT},
        '{"1.5e3",                 1'b1, NOT_INT},
        '{"9a",                    1'b1, NOT_INT}
    };

    // Every suffix the lexer accepts, plus the empty one
    string suffix_pool [23] = '{
        "", "u", "U", "l", "L", "ul", "uL", "Ul", "UL", "lu", "lU", "Lu", "LU",
        "ll", "LL", "llu", "llU", "LLu", "LLU", "ull", "uLL", "Ull", "ULL"
    };

    // DUT ports; those the testbench drives are known from time zero
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;

    // Stimulus and scoreboard
    char_item_t  char_stream [$];
    lex_result_t pending_results [$];
    int          send_idx     = 0;   // next character to offer, sender only
    int          taken_count  = 0;   // characters accepted so far
    int          results_seen = 0;   // results accepted so far
    int          fail_count   = 0;
    int          hold_left    = 0;   // cycles of receiver hold-off still to go
    logic        hold_done    = 1'b0;
    logic        steady;

    // Predictor state for the token in flight
    logic [1:0]  tok_count  = 2'd0;
    logic [15:0] tok_prefix = 16'd0;
    cilp_base_t  tok_base   = BASE_DEC;
    logic [63:0] tok_acc    = 64'd0;
    logic        tok_ovf    = 1'b0;
    cilp_phase_t tok_phase  = PH_DIGITS;
    logic [1:0]  tok_marks  = 2'd0;
    logic        tok_bad    = 1'b0;

    c_integer_literal_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // No idling on either side while this window of characters goes through
    assign steady = (taken_count >= STEADY_FROM) && (taken_count < STEADY_FROM + STEADY_SPAN);

    // Advance the token state by one character; on the last one, return the answer
    // and clear the state for the next token.
    function automatic logic lex_char(input logic [7:0] c, input logic last,
                                      output lex_result_t res);
        logic [7:0]  dval;
        logic [4:0]  radix;
        logic [7:0]  folded;
        logic [67:0] grown;
        logic        is_u;
        logic        long_m;
        logic        uns_m;
        res = NOT_INT;
        if (c >= "0" && c <= "9") begin
            dval = c - 8'h30;
        end else if (c >= "a" && c <= "f") begin
            dval = c - 8'h57;
        end else if (c >= "A" && c <= "F") begin
            dval = c - 8'h37;
        end else begin
            dval = 8'hFF;
        end
        case (tok_base)
            BASE_DEC: radix = 5'd10;
            BASE_OCT: radix = 5'd8;
            BASE_HEX: radix = 5'd16;
            default:  radix = 5'd2;
        endcase
        is_u = (c == "u") || (c == "U");

        if (!tok_bad) begin
            if (tok_count == 2'd0) begin
                // First character picks decimal or the leading-zero path
                tok_prefix = {c, 8'h00};
                if (c == "0") begin
                    tok_base = BASE_OCT;
                    tok_acc  = 64'd0;
                end else if (c >= "1" && c <= "9") begin
                    tok_base = BASE_DEC;
                    tok_acc  = {56'd0, dval};
                end else begin
                    tok_bad = 1'b1;
                end
            end else if (tok_phase == PH_PREFIX) begin
                // Character after 0x / 0b must be a digit of the new base
                folded    = tok_prefix[7:0] | 8'h20;
                tok_phase = PH_DIGITS;
                if (folded == "x" && dval < 8'd16) begin
                    tok_base = BASE_HEX;
                    tok_acc  = {56'd0, dval};
                end else if (folded == "b" && dval < 8'd2) begin
                    tok_base = BASE_BIN;
                    tok_acc  = {56'd0, dval};
                end else begin
                    tok_bad = 1'b1;
                end
            end else if (tok_count == 2'd1 && tok_base == BASE_OCT &&
                         ((c | 8'h20) == "x" || (c | 8'h20) == "b")) begin
                tok_prefix[7:0] = c;
                tok_phase       = PH_PREFIX;
            end else if (tok_phase == PH_DIGITS && dval < {3'd0, radix}) begin
                // Saturate to all ones once the value no longer fits
                if (!tok_ovf) begin
                    grown = {4'd0, tok_acc} * {63'd0, radix} + {60'd0, dval};
                    if (|grown[67:64]) begin
                        tok_acc = ALL_ONES;
                        tok_ovf = 1'b1;
                    end else begin
                        tok_acc = grown[63:0];
                    end
                end
            end else begin
                // Suffix walk: anything off the accepted spellings rejects the token
                case (tok_phase)
                    PH_DIGITS: begin
                        if (c == "L") begin
                            tok_phase = PH_L;
                            tok_marks = MARK_LONG;
                        end else if (c == "l") begin
                            tok_phase = PH_LOW_L;
                            tok_marks = MARK_LONG;
                        end else if (is_u) begin
                            tok_phase = PH_U;
                            tok_marks = MARK_UNSIGNED;
                        end else begin
                            tok_bad = 1'b1;
                        end
                    end
                    PH_L, PH_LOW_L: begin
                        if ((tok_phase == PH_L && c == "L") ||
                            (tok_phase == PH_LOW_L && c == "l")) begin
                            tok_phase = PH_LL;
                        end else if (is_u) begin
                            tok_phase = PH_DONE;
                            tok_marks = MARK_LONG | MARK_UNSIGNED;
                        end else begin
                            tok_bad = 1'b1;
                        end
                    end
                    PH_LL: begin
                        if (is_u) begin
                            tok_phase = PH_DONE;
                            tok_marks = MARK_LONG | MARK_UNSIGNED;
                        end else begin
                            tok_bad = 1'b1;
                        end
                    end
                    PH_U: begin
                        if (c == "L") begin
                            tok_phase = PH_UL;
                            tok_marks = MARK_LONG | MARK_UNSIGNED;
                        end else if (c == "l") begin
                            tok_phase = PH_ULOW;
                            tok_marks = MARK_LONG | MARK_UNSIGNED;
                        end else begin
                            tok_bad = 1'b1;
                        end
                    end
                    PH_UL: begin
                        if (c == "L") tok_phase = PH_DONE;
                        else          tok_bad = 1'b1;
                    end
                    PH_ULOW: begin
                        if (c == "l") tok_phase = PH_DONE;
                        else          tok_bad = 1'b1;
                    end
                    default: tok_bad = 1'b1;
                endcase
            end
        end
        if (tok_count != 2'd3) tok_count = tok_count + 2'd1;

        if (!last) return 1'b0;

        res.is_int = !tok_bad && (tok_phase != PH_PREFIX);
        if (res.is_int) begin
            res.value = tok_acc;
            long_m    = (tok_marks & MARK_LONG) != 2'd0;
            uns_m     = (tok_marks & MARK_UNSIGNED) != 2'd0;
            // Unsuffixed decimal climbs int -> long; other bases may land on the unsigned types
            if (long_m && uns_m) begin
                res.kind = TYPE_ULONG;
            end else if (tok_base == BASE_DEC) begin
                if (long_m)     res.kind = TYPE_LONG;
                else if (uns_m) res.kind = (|tok_acc[63:32]) ? TYPE_ULONG : TYPE_UINT;
                else            res.kind = (|tok_acc[63:31]) ? TYPE_LONG : TYPE_INT;
            end else begin
                if (long_m)                res.kind = tok_acc[63] ? TYPE_ULONG : TYPE_LONG;
                else if (uns_m)            res.kind = (|tok_acc[63:32]) ? TYPE_ULONG : TYPE_UINT;
                else if (tok_acc[63])      res.kind = TYPE_ULONG;
                else if (|tok_acc[62:32])  res.kind = TYPE_LONG;
                else if (tok_acc[31])      res.kind = TYPE_UINT;
                else                       res.kind = TYPE_INT;
            end
        end

        tok_count  = 2'd0;
        tok_prefix = 16'd0;
        tok_base   = BASE_DEC;
        tok_acc    = 64'd0;
        tok_ovf    = 1'b0;
        tok_phase  = PH_DIGITS;
        tok_marks  = 2'd0;
        tok_bad    = 1'b0;
        return 1'b1;
    endfunction

    // Queue one token as character transactions, last flag on the final one
    task automatic push_token(input logic [7:0] chars [$], input logic fixed,
                              input lex_result_t want);
        char_item_t item;
        for (int i = 0; i < chars.size(); i++) begin
            item.code  = chars[i];
            item.last  = (i == chars.size() - 1);
            item.fixed = fixed;
            item.want  = want;
            char_stream.push_back(item);
        end
    endtask

    // Sender: offer characters in order, idle at random, keep offering during the hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) send_idx = send_idx + 1;
            if (!s_tvalid || s_tready) begin
                if (send_idx < char_stream.size() &&
                    (steady || hold_left != 0 || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= char_stream[send_idx].code;
                    s_tlast  <= char_stream[send_idx].last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, none in the steady window, low through the hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Hold-off counter: once, after some results, drop ready long enough to fill the block
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Bus watcher: predict on each accepted character, then check each accepted result
    always @(posedge aclk) begin : watch_bus
        lex_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (lex_char(s_tdata, s_tlast, want)) begin
                    if (char_stream[taken_count].fixed) want = char_stream[taken_count].want;
                    pending_results.push_back(want);
                end
                taken_count <= taken_count + 1;
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing pending");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser[0] !== want.is_int) begin
                        $error("is_integer: expected %0d, got %0d", want.is_int, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[63:0] !== want.value) begin
                        $error("literal_value: expected %0h, got %0h", want.value, m_tdata[63:0]);
                        fail_count++;
                    end
                    if (m_tdata[65:64] !== want.kind) begin
                        $error("type_code: expected %0d, got %0d", want.kind, m_tdata[65:64]);
                        fail_count++;
                    end
                    if (m_tdata[71:66] !== 6'd0) begin
                        $error("tdata padding: expected 0, got %0h", m_tdata[71:66]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: a stuck handshake ends the run
    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge aclk);
        $display("FAIL c_integer_literal_parser");
        $finish;
    end

    // Build the character stream, release reset, wait for the last result, report
    initial begin : run_control
        logic [7:0] tok [$];
        int         roll;
        int         base_pick;
        int         radix;
        int         maxd;
        int         ndig;
        int         dv;
        int         pos;
        int         random_chars;
        string      sfx;

        // Directed tokens; map the two stand-in characters to the byte extremes
        foreach (token_rows[r]) begin
            tok.delete();
            for (int i = 0; i < token_rows[r].text.len(); i++) begin
                if (token_rows[r].text[i] == "#")      tok.push_back(8'h00);
                else if (token_rows[r].text[i] == "$") tok.push_back(8'hFF);
                else                                   tok.push_back(token_rows[r].text[i]);
            end
            push_token(tok, token_rows[r].fixed, token_rows[r].want);
        end

        // Random tokens: mostly well-formed numbers with random digits and suffix,
        // some with one byte corrupted or inserted, the rest raw noise
        random_chars = 0;
        while (random_chars < RANDOM_CHARS) begin
            tok.delete();
            roll = $urandom_range(99);
            if (roll < 88) begin
                base_pick = $urandom_range(3);
                case (base_pick)
                    0: begin radix = 10; maxd = 21; end
                    1: begin radix = 8;  maxd = 23; tok.push_back("0"); end
                    2: begin
                        radix = 16; maxd = 17;
                        tok.push_back("0");
                        tok.push_back($urandom_range(1) ? "x" : "X");
                    end
                    default: begin
                        radix = 2; maxd = 65;
                        tok.push_back("0");
                        tok.push_back($urandom_range(1) ? "b" : "B");
                    end
                endcase
                // Short numbers mostly; a quarter sit near the 64-bit boundary
                if ($urandom_range(3) == 0) ndig = $urandom_range(maxd, maxd - 4);
                else                        ndig = $urandom_range(6, 1);
                if (base_pick == 1) ndig = ndig - 1;
                for (int k = 0; k < ndig; k++) begin
                    dv = $urandom_range(radix - 1);
                    if (k == 0 && base_pick == 0 && dv == 0) dv = $urandom_range(9, 1);
                    if (dv < 10) tok.push_back(8'(8'h30 + dv));
                    else         tok.push_back(8'(($urandom_range(1) ? 8'h61 : 8'h41) + dv - 10));
                end
                if ($urandom_range(9) >= 3) begin
                    sfx = suffix_pool[$urandom_range(22)];
                    for (int i = 0; i < sfx.len(); i++) tok.push_back(sfx[i]);
                end
                if (roll >= 76) begin
                    pos = $urandom_range(tok.size() - 1);
                    if ($urandom_range(1)) tok[pos] = 8'($urandom_range(255));
                    else                   tok.insert(pos, 8'($urandom_range(255)));
                end
            end else begin
                repeat ($urandom_range(4, 1)) tok.push_back(8'($urandom_range(255)));
            end
            random_chars += tok.size();
            push_token(tok, 1'b0, NOT_INT);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Hold until every character is in and every answer is out, then drain
        while (taken_count != char_stream.size() || pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0) begin
            $display("PASS c_integer_literal_parser");
        end else begin
            $display("FAIL c_integer_literal_parser");
        end
        $finish;
    end

endmodule
